FILE: rtl/lcar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_pkg
// Shared types and constants of the load cell ADC reader: register indexes,
// field widths, stream packing positions and the per-tick flag group.
// ----------------------------------------------------------------------------
package lcar_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_OFFSET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SCALE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_READY_TIMEOUT_MS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD_MS = 2'd3;
    localparam int CFG_DATA_W = 32;

    // Field widths
    localparam int OFFSET_W = 24;
    localparam int SCALE_W  = 32;
    localparam int MS_W     = 16;
    localparam int RAW_W    = 24;
    localparam int WEIGHT_W = 32;
    localparam int FRAC_SHIFT = 24;   // Q16.16 divisor, Q24.8 quotient

    // Register reset values
    localparam logic signed [OFFSET_W-1:0] OFFSET_RST  = '0;
    localparam logic signed [SCALE_W-1:0]  SCALE_RST   = 32'sd65536;
    localparam logic [MS_W-1:0]            TIMEOUT_RST = 16'd1000;
    localparam logic [MS_W-1:0]            PERIOD_RST  = 16'd100;
    localparam logic [MS_W-1:0]            MS_MAX      = '1;

    // Stream packing
    localparam int IN_TDATA_W  = 8;
    localparam int IN_DOUT_BIT = 0;
    localparam int IN_MS_BIT   = 1;

    localparam int OUT_TDATA_W    = 64;
    localparam int OUT_SCK_BIT    = 0;
    localparam int OUT_DONE_BIT   = 1;
    localparam int OUT_VALID_BIT  = 2;
    localparam int OUT_TMO_BIT    = 3;
    localparam int OUT_RAW_LSB    = 4;
    localparam int OUT_WEIGHT_LSB = OUT_RAW_LSB + RAW_W;
    localparam int OUT_STABLE_BIT = OUT_WEIGHT_LSB + WEIGHT_W;
    localparam int OUT_PAD_LSB    = OUT_STABLE_BIT + 1;

    // Per-tick status flags
    typedef struct packed {
        logic sck_level;
        logic reading_done;
        logic reading_valid;
        logic timed_out;
    } lcar_flags_t;

endpackage

FILE: rtl/load_cell_adc_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_adc_reader
// Bridge ADC serial readout with Q24.8 weight conversion and stability flag.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on s_* is one half-bit tick: the sampled data pin
//   level and a millisecond strobe. Every tick yields exactly one output
//   transaction on m_* carrying the clock pin level for that half bit and,
//   on the tick that ends an attempt, the reading (count, weight, flags).
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
//   Throughput: one tick per cycle while s_tready is high. A tick's result
//   is registered in the stage register (sequencer/divider step) and then
//   in the output register (saturation and stability), which drives m_*.
//   A conversion spans the pause, the ready wait, 2*SAMPLE_BITS+2 shift
//   ticks and SAMPLE_BITS+25 divider ticks, one quotient bit per tick.
//   Reset clears the sequencer to the pause phase, loads register defaults
//   and marks the previous weight usable. When m_tready is low the output
//   register holds, the stage register fills, and s_tready then drops until
//   the receiver takes the pending result.
// ----------------------------------------------------------------------------
module load_cell_adc_reader #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // s_tdata: [0] dout_level, [1] ms_tick
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lcar_pkg::IN_TDATA_W-1:0]       s_tdata,
    // m_tdata: [0] sck_level, [1] reading_done, [2] reading_valid,
    // [3] timed_out, [27:4] raw_value, [59:28] weight_q8, [60] stable
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lcar_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                  cfg_we,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lcar_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int DIV_BITS = SAMPLE_BITS + 25;

    // Configuration registers
    logic signed [lcar_pkg::OFFSET_W-1:0] offset_reg;
    logic signed [lcar_pkg::SCALE_W-1:0]  scale_reg;
    logic [lcar_pkg::MS_W-1:0]            timeout_reg;
    logic [lcar_pkg::MS_W-1:0]            period_reg;

    logic                          step_en;
    lcar_pkg::lcar_flags_t         seq_flags;
    logic [lcar_pkg::RAW_W-1:0]    seq_raw;
    logic                          div_start;
    logic [DIV_BITS-1:0]           div_work_init;
    logic [lcar_pkg::SCALE_W-1:0]  div_divisor;
    logic                          div_neg;
    logic                          div_last;
    logic [DIV_BITS-1:0]           div_q;
    logic                          div_q_neg;

    // Stage register between the step logic and the result stage
    logic                          stg_valid_reg;
    lcar_pkg::lcar_flags_t         stg_flags_reg;
    logic [lcar_pkg::RAW_W-1:0]    stg_raw_reg;
    logic [DIV_BITS-1:0]           stg_q_reg;
    logic                          stg_neg_reg;
    logic                          post_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= lcar_pkg::OFFSET_RST;
            scale_reg   <= lcar_pkg::SCALE_RST;
            timeout_reg <= lcar_pkg::TIMEOUT_RST;
            period_reg  <= lcar_pkg::PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lcar_pkg::REG_WEIGHT_OFFSET:
                    offset_reg  <= cfg_data[lcar_pkg::OFFSET_W-1:0];
                lcar_pkg::REG_WEIGHT_SCALE:
                    scale_reg   <= cfg_data[lcar_pkg::SCALE_W-1:0];
                lcar_pkg::REG_READY_TIMEOUT_MS:
                    timeout_reg <= cfg_data[lcar_pkg::MS_W-1:0];
                lcar_pkg::REG_SAMPLE_PERIOD_MS:
                    period_reg  <= cfg_data[lcar_pkg::MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign s_tready = !stg_valid_reg || post_ready;
    assign step_en  = s_tvalid && s_tready;

    lcar_seq #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DIV_BITS    (DIV_BITS)
    ) u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_en          (step_en),
        .dout_level       (s_tdata[lcar_pkg::IN_DOUT_BIT]),
        .ms_tick          (s_tdata[lcar_pkg::IN_MS_BIT]),
        .weight_offset    (offset_reg),
        .weight_scale     (scale_reg),
        .ready_timeout_ms (timeout_reg),
        .sample_period_ms (period_reg),
        .div_last         (div_last),
        .flags            (seq_flags),
        .raw_value        (seq_raw),
        .div_start        (div_start),
        .div_work_init    (div_work_init),
        .div_divisor      (div_divisor),
        .div_neg          (div_neg)
    );

    lcar_div #(
        .DIV_BITS (DIV_BITS)
    ) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .start        (div_start),
        .work_init    (div_work_init),
        .divisor      (div_divisor),
        .neg          (div_neg),
        .last         (div_last),
        .quotient     (div_q),
        .quotient_neg (div_q_neg)
    );

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            stg_valid_reg <= 1'b1;
        end
        else if (post_ready)
        begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            stg_flags_reg <= seq_flags;
            stg_raw_reg   <= seq_raw;
            stg_q_reg     <= div_q;
            stg_neg_reg   <= div_q_neg;
        end
    end

    lcar_post #(
        .Q_W (DIV_BITS)
    ) u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (stg_valid_reg),
        .item_ready (post_ready),
        .item_flags (stg_flags_reg),
        .item_raw   (stg_raw_reg),
        .item_q     (stg_q_reg),
        .item_neg   (stg_neg_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: rtl/lcar_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_seq
// Conversion sequencer: sample pause, data-ready wait with timeout, serial
// shift of the converter count and launch of the weight division.
// ----------------------------------------------------------------------------
module lcar_seq #(
    parameter int SAMPLE_BITS = 24,
    parameter int DIV_BITS    = SAMPLE_BITS + 25
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  step_en,
    input  logic                                  dout_level,
    input  logic                                  ms_tick,
    input  logic signed [lcar_pkg::OFFSET_W-1:0]  weight_offset,
    input  logic signed [lcar_pkg::SCALE_W-1:0]   weight_scale,
    input  logic [lcar_pkg::MS_W-1:0]             ready_timeout_ms,
    input  logic [lcar_pkg::MS_W-1:0]             sample_period_ms,
    input  logic                                  div_last,
    output lcar_pkg::lcar_flags_t                 flags,
    output logic [lcar_pkg::RAW_W-1:0]            raw_value,
    output logic                                  div_start,
    output logic [DIV_BITS-1:0]                   div_work_init,
    output logic [lcar_pkg::SCALE_W-1:0]          div_divisor,
    output logic                                  div_neg
);

    localparam int HB_W      = $clog2(2 * SAMPLE_BITS + 2);
    localparam int RAW_EXT_W = (SAMPLE_BITS > lcar_pkg::RAW_W) ? SAMPLE_BITS
                                                               : lcar_pkg::RAW_W;
    localparam int DIFF_W    = RAW_EXT_W + 1;
    localparam logic [HB_W-1:0] HB_LAST = HB_W'(2 * SAMPLE_BITS);

    typedef enum logic [3:0] {
        PH_PERIOD = 4'b0001,
        PH_READY  = 4'b0010,
        PH_SHIFT  = 4'b0100,
        PH_DIVIDE = 4'b1000
    } phase_t;

    phase_t                         phase_reg, phase_next;
    logic [HB_W-1:0]                hb_reg, hb_next;
    logic [SAMPLE_BITS-1:0]         sw_reg, sw_next;
    logic [lcar_pkg::MS_W-1:0]      ms_reg, ms_next;
    logic                           raw_sel;

    logic signed [RAW_EXT_W-1:0]    raw_ext;
    logic signed [DIFF_W-1:0]       diff;
    logic [DIFF_W-1:0]              diff_mag;
    logic [DIFF_W+lcar_pkg::FRAC_SHIFT-1:0] diff_shifted;

    // Count, difference to tare, and divider operands
    always_comb
    begin
        raw_ext      = RAW_EXT_W'($signed(sw_reg));
        diff         = DIFF_W'(raw_ext) - DIFF_W'(weight_offset);
        diff_mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        diff_shifted = {diff_mag, {lcar_pkg::FRAC_SHIFT{1'b0}}};
    end

    assign div_work_init = diff_shifted[DIV_BITS-1:0];
    assign div_divisor   = weight_scale[lcar_pkg::SCALE_W-1]
                         ? lcar_pkg::SCALE_W'(-weight_scale)
                         : lcar_pkg::SCALE_W'(weight_scale);
    assign div_neg       = diff[DIFF_W-1] ^ weight_scale[lcar_pkg::SCALE_W-1];
    assign raw_value     = raw_sel ? raw_ext[lcar_pkg::RAW_W-1:0] : '0;

    // Phase sequencing, one step per tick
    always_comb
    begin
        phase_next = phase_reg;
        hb_next    = hb_reg;
        sw_next    = sw_reg;
        ms_next    = ms_reg;
        flags      = '0;
        raw_sel    = 1'b0;
        div_start  = 1'b0;
        unique case (phase_reg)
            PH_PERIOD:
            begin
                if (ms_reg >= sample_period_ms)
                begin
                    phase_next = PH_READY;
                    ms_next    = '0;
                end
                else if (ms_tick && ms_reg != lcar_pkg::MS_MAX)
                begin
                    ms_next = ms_reg + 1'b1;
                end
            end
            PH_READY:
            begin
                if (!dout_level)
                begin
                    phase_next = PH_SHIFT;
                    hb_next    = '0;
                    sw_next    = '0;
                end
                else if (ms_reg >= ready_timeout_ms)
                begin
                    flags.reading_done = 1'b1;
                    flags.timed_out    = 1'b1;
                    phase_next         = PH_PERIOD;
                    ms_next            = '0;
                end
                else if (ms_tick && ms_reg != lcar_pkg::MS_MAX)
                begin
                    ms_next = ms_reg + 1'b1;
                end
            end
            PH_SHIFT:
            begin
                if (!hb_reg[0])
                begin
                    // rising half of a clock pulse, including the extra pulse
                    flags.sck_level = 1'b1;
                    hb_next         = hb_reg + 1'b1;
                end
                else if (hb_reg < HB_LAST)
                begin
                    sw_next = {sw_reg[SAMPLE_BITS-2:0], dout_level};
                    hb_next = hb_reg + 1'b1;
                end
                else
                begin
                    hb_next = '0;
                    if (weight_scale == '0)
                    begin
                        flags.reading_done = 1'b1;
                        raw_sel            = 1'b1;
                        phase_next         = PH_PERIOD;
                        ms_next            = '0;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        phase_next = PH_DIVIDE;
                    end
                end
            end
            PH_DIVIDE:
            begin
                if (div_last)
                begin
                    flags.reading_done  = 1'b1;
                    flags.reading_valid = 1'b1;
                    raw_sel             = 1'b1;
                    phase_next          = PH_PERIOD;
                    ms_next             = '0;
                end
            end
            default:
            begin
                phase_next = PH_PERIOD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PERIOD;
            hb_reg    <= '0;
            sw_reg    <= '0;
            ms_reg    <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            hb_reg    <= hb_next;
            sw_reg    <= sw_next;
            ms_reg    <= ms_next;
        end
    end

endmodule

FILE: rtl/lcar_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_div
// Restoring divider for the weight: one quotient bit per tick, divisor and
// sign latched when a division is launched.
// ----------------------------------------------------------------------------
module lcar_div #(
    parameter int DIV_BITS = 49
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step_en,
    input  logic                               start,
    input  logic [DIV_BITS-1:0]                work_init,
    input  logic [lcar_pkg::SCALE_W-1:0]       divisor,
    input  logic                               neg,
    output logic                               last,
    output logic [DIV_BITS-1:0]                quotient,
    output logic                               quotient_neg
);

    localparam int STEP_W = $clog2(DIV_BITS);
    localparam int REM_W  = lcar_pkg::SCALE_W;

    logic                 busy_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [DIV_BITS-1:0]  work_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     div_reg;
    logic                 neg_reg;

    logic [REM_W:0]       rem_shift;
    logic [REM_W:0]       rem_sub;
    logic                 ge;

    // One restoring step
    always_comb
    begin
        rem_shift = {rem_reg, work_reg[DIV_BITS-1]};
        rem_sub   = rem_shift - {1'b0, div_reg};
        ge        = rem_shift >= {1'b0, div_reg};
    end

    assign quotient     = {work_reg[DIV_BITS-2:0], ge};
    assign quotient_neg = neg_reg;
    assign last         = busy_reg && (step_reg == STEP_W'(DIV_BITS - 1));

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (step_en)
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            if (start)
            begin
                work_reg <= work_init;
                rem_reg  <= '0;
                div_reg  <= divisor;
                neg_reg  <= neg;
            end
            else if (busy_reg)
            begin
                work_reg <= quotient;
                rem_reg  <= ge ? rem_sub[REM_W-1:0] : rem_shift[REM_W-1:0];
            end
        end
    end

endmodule

FILE: rtl/lcar_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_post
// Result stage: saturates the signed quotient to Q24.8, judges stability
// against the previous weight and holds the output register.
// ----------------------------------------------------------------------------
module lcar_post #(
    parameter int Q_W = 49
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  lcar_pkg::lcar_flags_t                item_flags,
    input  logic [lcar_pkg::RAW_W-1:0]           item_raw,
    input  logic [Q_W-1:0]                       item_q,
    input  logic                                 item_neg,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lcar_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int W = lcar_pkg::WEIGHT_W;
    localparam logic [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

    logic                          out_valid_reg;
    logic [lcar_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [W-1:0]                  prev_weight_reg;
    logic                          prev_usable_reg;

    logic                          take;
    logic                          q_big;
    logic [W-1:0]                  weight;
    logic [W:0]                    delta;
    logic                          close;
    logic                          stable;
    logic [lcar_pkg::OUT_TDATA_W-1:0] packed_item;

    assign item_ready = !out_valid_reg || m_tready;
    assign take       = item_valid && item_ready;

    // Saturation and stability
    always_comb
    begin
        q_big = |item_q[Q_W-1:W-1];
        if (!item_flags.reading_valid)
        begin
            weight = '0;
        end
        else if (item_neg)
        begin
            weight = q_big ? W_MIN : W'(-item_q[W-1:0]);
        end
        else
        begin
            weight = (q_big || &item_q[W-2:0]) ? W_MAX : item_q[W-1:0];
        end
        delta  = {weight[W-1], weight} - {prev_weight_reg[W-1], prev_weight_reg};
        // |delta| below one gram (256 in Q24.8)
        close  = (delta[W:8] == '0) || ((&delta[W:8]) && (delta[7:0] != '0));
        stable = item_flags.reading_valid && prev_usable_reg && close;
    end

    // Field packing, first field in the lowest bits
    always_comb
    begin
        packed_item = '0;
        packed_item[lcar_pkg::OUT_SCK_BIT]   = item_flags.sck_level;
        packed_item[lcar_pkg::OUT_DONE_BIT]  = item_flags.reading_done;
        packed_item[lcar_pkg::OUT_VALID_BIT] = item_flags.reading_valid;
        packed_item[lcar_pkg::OUT_TMO_BIT]   = item_flags.timed_out;
        packed_item[lcar_pkg::OUT_RAW_LSB +: lcar_pkg::RAW_W]   = item_raw;
        packed_item[lcar_pkg::OUT_WEIGHT_LSB +: W]              = weight;
        packed_item[lcar_pkg::OUT_STABLE_BIT] = stable;
    end

    // Output register and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            prev_weight_reg <= '0;
            prev_usable_reg <= 1'b1;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
                if (item_flags.reading_valid)
                begin
                    prev_weight_reg <= weight;
                    prev_usable_reg <= 1'b1;
                end
                else if (item_flags.reading_done && !item_flags.timed_out)
                begin
                    prev_usable_reg <= 1'b0;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= packed_item;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/lcar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_checker
// Port-level checks of the reader's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module lcar_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lcar_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Ticks that end no attempt carry only the clock level
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[lcar_pkg::OUT_DONE_BIT]
        |-> m_tdata[lcar_pkg::OUT_TDATA_W-1:lcar_pkg::OUT_DONE_BIT] == '0)
        else $error("fields set on a tick without a completed attempt");

    // Timeout is a completed, unusable attempt with zero payload
    a_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[lcar_pkg::OUT_TMO_BIT]
        |-> m_tdata[lcar_pkg::OUT_DONE_BIT] && !m_tdata[lcar_pkg::OUT_VALID_BIT]
            && m_tdata[lcar_pkg::OUT_TDATA_W-1:lcar_pkg::OUT_RAW_LSB] == '0)
        else $error("malformed timeout result");

    // Stable only on a valid reading
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[lcar_pkg::OUT_STABLE_BIT]
        |-> m_tdata[lcar_pkg::OUT_VALID_BIT])
        else $error("stable flagged on an unusable reading");

    // Clock pulses never coincide with a completed attempt
    a_sck_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[lcar_pkg::OUT_SCK_BIT]
        |-> !m_tdata[lcar_pkg::OUT_DONE_BIT])
        else $error("clock pulse on a completing tick");

endmodule

bind load_cell_adc_reader lcar_checker u_lcar_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
